[hw/rtl/chgs_pkg.sv]
// Shared types and constants for the convex hull block.
`timescale 1ns / 1ps
package chgs_pkg;
  localparam int unsigned IdxWidth = 6;
  localparam int unsigned InCoordWidth = 16;

  typedef logic [IdxWidth-1:0] hull_idx_t;
  typedef logic signed [InCoordWidth-1:0] coord_t;

  // Sequencer state codes.
  localparam logic [4:0] ST_LOAD    = 5'd0;
  localparam logic [4:0] ST_PIVOT   = 5'd1;
  localparam logic [4:0] ST_FILLP   = 5'd2;
  localparam logic [4:0] ST_FILL    = 5'd3;
  localparam logic [4:0] ST_SORTRD  = 5'd4;
  localparam logic [4:0] ST_SORTCUR = 5'd5;
  localparam logic [4:0] ST_SORTPT  = 5'd6;
  localparam logic [4:0] ST_SORTDA  = 5'd7;
  localparam logic [4:0] ST_CMPRD   = 5'd8;
  localparam logic [4:0] ST_CMPO    = 5'd9;
  localparam logic [4:0] ST_CMPPT   = 5'd10;
  localparam logic [4:0] ST_CMPMUL  = 5'd11;
  localparam logic [4:0] ST_CMPDEC  = 5'd12;
  localparam logic [4:0] ST_SORTPUT = 5'd13;
  localparam logic [4:0] ST_SCANRD  = 5'd14;
  localparam logic [4:0] ST_SCANA   = 5'd15;
  localparam logic [4:0] ST_SCANB   = 5'd16;
  localparam logic [4:0] ST_SCANC   = 5'd17;
  localparam logic [4:0] ST_SCAND   = 5'd18;
  localparam logic [4:0] ST_SCANMUL = 5'd19;
  localparam logic [4:0] ST_SCANDEC = 5'd20;
  localparam logic [4:0] ST_EMITRD  = 5'd21;
  localparam logic [4:0] ST_EMITSET = 5'd22;
  localparam logic [4:0] ST_DRAIN   = 5'd23;
endpackage

[hw/rtl/chgs_if.sv]
// Valid/ready channel interfaces for points in and hull vertices out.
`timescale 1ns / 1ps
interface chgs_point_if;
  import chgs_pkg::*;
  logic   valid;
  logic   ready;
  coord_t coord_x;
  coord_t coord_y;
  logic   final_point;
  modport source (output valid, coord_x, coord_y, final_point, input ready);
  modport sink (input valid, coord_x, coord_y, final_point, output ready);
endinterface

interface chgs_hull_if;
  import chgs_pkg::*;
  logic      valid;
  logic      ready;
  hull_idx_t hull_index;
  logic      hull_last;
  modport source (output valid, hull_index, hull_last, input ready);
  modport sink (input valid, hull_index, hull_last, output ready);
endinterface

[hw/rtl/convex_hull_graham_scan.sv]
// Convex hull of a loaded point set by Graham scan, memory based sequencer.
//
// Usage: points arrive on the in channel, one item per point, and are stored
// in load order at one item per cycle. The item with final_point set starts
// the hull and input ready stays low until the last vertex has left.
// Per set of N points: pivot search, order fill, then an insertion sort by
// polar angle (at most (N-1)*(N-2)/2 comparisons), then the scan (at most
// 2*(N-2) steps), then the emit of each hull vertex. The run time is set
// by the single read port of the order memory and the point memories and
// by one shared multiplier.
// When the receiver stalls, the current vertex holds in the output register
// and the sequencer waits. Reset returns the block to loading with an empty
// set; the memories are not cleared and only entries already written are read.
// Points beyond MAX_POINTS are dropped; a final_point item still starts the
// hull on the points held. Sets of one or two points skip the sort and scan.
`timescale 1ns / 1ps
module convex_hull_graham_scan #(
  parameter int MAX_POINTS = 64
) (
  input logic clk,
  input logic rst,
  chgs_point_if.sink   in_pt,
  chgs_hull_if.source  out_hull
);
  import chgs_pkg::*;

  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW   = InCoordWidth;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;

  // Point memories and the order / stack memory.
  coord_t          mem_x [MAX_POINTS];
  coord_t          mem_y [MAX_POINTS];
  logic [AW-1:0]   mem_o [MAX_POINTS];

  logic [4:0]      state;
  logic [CntW-1:0] count, n, i, j, top, scan;
  logic [CntW-1:0] cnt_inc;
  logic [AW-1:0]   pivot, cur, prev_e, sc;
  coord_t          base_x, base_y;
  coord_t          rd_x, rd_y;
  logic [AW-1:0]   rd_o;
  logic [1:0]      phase;
  logic signed [DW-1:0] d0x, d0y, d1x, d1y, dx_now, dy_now;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p, acc;
  logic signed [SW-1:0] diff_now, sum_now, cross_r, da_r, db_r;
  logic            az, bz, cross_pos, before_c;
  logic            out_valid;
  hull_idx_t       out_idx;
  logic            out_last;

  // Memory port controls.
  logic            pt_we, o_we;
  logic [AW-1:0]   pt_waddr, pt_raddr, o_waddr, o_raddr;
  logic [AW-1:0]   o_wdata;

  // Point memories, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (pt_we) begin
      mem_x[pt_waddr] <= in_pt.coord_x;
      mem_y[pt_waddr] <= in_pt.coord_y;
    end
    rd_x <= mem_x[pt_raddr];
    rd_y <= mem_y[pt_raddr];
  end

  // Order memory, later reused as the scan stack.
  always_ff @(posedge clk) begin
    if (o_we) begin
      mem_o[o_waddr] <= o_wdata;
    end
    rd_o <= mem_o[o_raddr];
  end

  assign in_pt.ready         = (state == ST_LOAD);
  assign out_hull.valid      = out_valid;
  assign out_hull.hull_index = out_idx;
  assign out_hull.hull_last  = out_last;

  // Offset of the point just read from the base point (pivot or stack entry).
  assign dx_now = DW'(rd_x) - DW'(base_x);
  assign dy_now = DW'(rd_y) - DW'(base_y);
  assign az = (d0x == '0) && (d0y == '0);
  assign bz = (d1x == '0) && (d1y == '0);

  // One multiplier, shared over phases.
  always_comb begin
    case (phase)
      2'd0:    begin mul_a = d0x; mul_b = d1y; end
      2'd1:    begin mul_a = d0y; mul_b = d1x; end
      2'd2:    begin mul_a = d1x; mul_b = d1x; end
      default: begin mul_a = d1y; mul_b = d1y; end
    endcase
    if (state == ST_SORTDA) begin
      mul_a = phase[0] ? d0y : d0x;
      mul_b = phase[0] ? d0y : d0x;
    end
  end
  assign mul_p    = PW'(mul_a) * PW'(mul_b);
  assign diff_now = SW'(acc) - SW'(mul_p);
  assign sum_now  = SW'(acc) + SW'(mul_p);
  assign cross_pos = !cross_r[SW-1] && (cross_r != '0);

  // Sort test: does cur go ahead of the entry held in prev_e?
  always_comb begin
    if (az != bz) before_c = az;
    else if (!az && cross_r != '0) before_c = cross_pos;
    else if (da_r != db_r) before_c = (da_r < db_r);
    else before_c = (cur < prev_e);
  end

  assign cnt_inc = count + 1'b1;

  // Sequencer: load, pivot, fill, sort, scan, emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      phase <= '0;
    end else begin
      case (state)
        // Store points; the final one starts the run.
        ST_LOAD: begin
          if (in_pt.valid) begin
            if (in_pt.final_point) begin
              n     <= (count < CntW'(MAX_POINTS)) ? cnt_inc : count;
              count <= '0;
              i     <= '0;
              state <= ST_PIVOT;
            end else if (count < CntW'(MAX_POINTS)) begin
              count <= cnt_inc;
            end
          end
        end
        // Pivot search, one point read per cycle; rd holds point i-1.
        ST_PIVOT: begin
          if (i != '0) begin
            if (i == CntW'(1) || rd_y < base_y || (rd_y == base_y && rd_x < base_x)) begin
              pivot  <= AW'(i - 1'b1);
              base_x <= rd_x;
              base_y <= rd_y;
            end
          end
          if (i == n) begin
            state <= ST_FILLP;
          end else begin
            i <= i + 1'b1;
          end
        end
        // The pivot goes to the front of the order.
        ST_FILLP: begin
          i     <= '0;
          j     <= CntW'(1);
          state <= ST_FILL;
        end
        // The other points follow in load order.
        ST_FILL: begin
          if (i == n) begin
            if (n <= CntW'(2)) begin
              top   <= n - 1'b1;
              i     <= '0;
              state <= ST_EMITRD;
            end else begin
              i     <= CntW'(2);
              state <= ST_SORTRD;
            end
          end else begin
            if (AW'(i) != pivot) j <= j + 1'b1;
            i <= i + 1'b1;
          end
        end
        // Insertion sort: fetch cur = order[i].
        ST_SORTRD: begin
          if (i == n) begin
            top   <= CntW'(1);
            scan  <= CntW'(2);
            state <= ST_SCANRD;
          end else begin
            state <= ST_SORTCUR;
          end
        end
        ST_SORTCUR: begin
          cur   <= rd_o;
          j     <= i;
          state <= ST_SORTPT;
        end
        ST_SORTPT: begin
          d0x   <= dx_now;
          d0y   <= dy_now;
          phase <= '0;
          state <= ST_SORTDA;
        end
        // Squared distance of cur from the pivot.
        ST_SORTDA: begin
          if (phase == 2'd0) begin
            acc   <= mul_p;
            phase <= 2'd1;
          end else begin
            da_r  <= sum_now;
            phase <= '0;
            state <= ST_CMPRD;
          end
        end
        // Compare cur against order[j-1]: read it, then its point.
        ST_CMPRD: begin
          if (j <= CntW'(1)) begin
            state <= ST_SORTPUT;
          end else begin
            state <= ST_CMPO;
          end
        end
        ST_CMPO: begin
          prev_e <= rd_o;
          state  <= ST_CMPPT;
        end
        ST_CMPPT: begin
          d1x   <= dx_now;
          d1y   <= dy_now;
          phase <= '0;
          state <= ST_CMPMUL;
        end
        // Cross product, then squared distance of the stored entry.
        ST_CMPMUL: begin
          phase <= phase + 1'b1;
          case (phase)
            2'd0:    acc <= mul_p;
            2'd1:    cross_r <= diff_now;
            2'd2:    acc <= mul_p;
            default: begin
              db_r  <= sum_now;
              state <= ST_CMPDEC;
            end
          endcase
        end
        // Shift the stored entry up, or stop and place cur.
        ST_CMPDEC: begin
          if (before_c) begin
            j     <= j - 1'b1;
            state <= ST_CMPRD;
          end else begin
            state <= ST_SORTPUT;
          end
        end
        ST_SORTPUT: begin
          i     <= i + 1'b1;
          state <= ST_SORTRD;
        end
        // Scan: read stack entries top-1, top and the scanned entry.
        ST_SCANRD: begin
          if (scan == n) begin
            i     <= '0;
            state <= ST_EMITRD;
          end else begin
            state <= ST_SCANA;
          end
        end
        ST_SCANA: begin
          state <= ST_SCANB;
        end
        ST_SCANB: begin
          base_x <= rd_x;
          base_y <= rd_y;
          state  <= ST_SCANC;
        end
        ST_SCANC: begin
          sc    <= rd_o;
          d0x   <= dx_now;
          d0y   <= dy_now;
          state <= ST_SCAND;
        end
        ST_SCAND: begin
          d1x   <= dx_now;
          d1y   <= dy_now;
          phase <= '0;
          state <= ST_SCANMUL;
        end
        ST_SCANMUL: begin
          if (phase == 2'd0) begin
            acc   <= mul_p;
            phase <= 2'd1;
          end else begin
            cross_r <= diff_now;
            phase   <= '0;
            state   <= ST_SCANDEC;
          end
        end
        // Left turn pushes; otherwise pop, but never below two entries.
        ST_SCANDEC: begin
          if (cross_pos) begin
            top  <= top + 1'b1;
            scan <= scan + 1'b1;
          end else if (top > CntW'(1)) begin
            top <= top - 1'b1;
          end else begin
            scan <= scan + 1'b1;
          end
          state <= ST_SCANRD;
        end
        // Emit stack bottom to top once the output register is free.
        ST_EMITRD: begin
          if (!out_valid || out_hull.ready) begin
            state <= ST_EMITSET;
          end
        end
        ST_EMITSET: begin
          out_idx  <= IdxWidth'(rd_o);
          out_last <= (i == top);
          if (i == top) begin
            state <= ST_DRAIN;
          end else begin
            i     <= i + 1'b1;
            state <= ST_EMITRD;
          end
        end
        // Wait for the last vertex to leave before loading again.
        ST_DRAIN: begin
          if (!out_valid || out_hull.ready) begin
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Output valid: set with a new vertex, cleared when the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMITSET) begin
      out_valid <= 1'b1;
    end else if (out_hull.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Memory addresses and writes, driven by the sequencer state.
  always_comb begin
    pt_we    = (state == ST_LOAD) && in_pt.valid && (count < CntW'(MAX_POINTS));
    pt_waddr = AW'(count);
    pt_raddr = AW'(i);
    o_we     = 1'b0;
    o_waddr  = AW'(j);
    o_wdata  = cur;
    o_raddr  = AW'(i);
    case (state)
      ST_FILLP: begin
        o_we    = 1'b1;
        o_waddr = '0;
        o_wdata = pivot;
      end
      ST_FILL: begin
        o_we    = (i != n) && (AW'(i) != pivot);
        o_wdata = AW'(i);
      end
      ST_SORTCUR: pt_raddr = rd_o;
      ST_CMPRD:   o_raddr  = AW'(j - 1'b1);
      ST_CMPO:    pt_raddr = rd_o;
      ST_CMPDEC: begin
        o_we    = before_c;
        o_wdata = prev_e;
      end
      ST_SORTPUT: o_we = 1'b1;
      ST_SCANRD:  o_raddr = AW'(top - 1'b1);
      ST_SCANA: begin
        o_raddr  = AW'(top);
        pt_raddr = rd_o;
      end
      ST_SCANB: begin
        o_raddr  = AW'(scan);
        pt_raddr = rd_o;
      end
      ST_SCANC: pt_raddr = rd_o;
      ST_SCANDEC: begin
        if (cross_pos) begin
          o_we    = 1'b1;
          o_waddr = AW'(top + 1'b1);
          o_wdata = sc;
        end else if (top <= CntW'(1)) begin
          o_we    = 1'b1;
          o_waddr = AW'(1);
          o_wdata = sc;
        end
      end
      default: ;
    endcase
  end
endmodule

[hw/rtl/chgs_checker.sv]
// Port level checks for the convex hull block, bound to the top level.
`timescale 1ns / 1ps
module chgs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [5:0] hull_index,
  input logic hull_last
);
  // No input is taken while vertices are pending.
  a_no_load_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while emitting");
  // Stalled vertex holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hull_index) && $stable(hull_last))
    else $error("stalled vertex changed");
  // After the last vertex the block returns to loading soon.
  a_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && hull_last |=> in_ready)
    else $error("not ready after run");
  // Reset clears the output.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind convex_hull_graham_scan chgs_checker u_chgs_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_pt.valid), .in_ready(in_pt.ready),
  .out_valid(out_hull.valid), .out_ready(out_hull.ready),
  .hull_index(out_hull.hull_index), .hull_last(out_hull.hull_last)
);
